// File: design/hagc_pkg.sv
// Package for the hang AGC block: shared types, register indexes and constants.
// No dependencies.
package hagc_pkg;

  localparam int GAIN_BITS   = 24;
  localparam int WEIGHT_BITS = 17;
  localparam int HANG_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENABLE    = 3'd0,
    REG_GAIN_TOP  = 3'd1,
    REG_GAIN_BOT  = 3'd2,
    REG_HANG_THR  = 3'd3,
    REG_HANG_SMP  = 3'd4,
    REG_ATTACK_W  = 3'd5,
    REG_DECAY_W   = 3'd6,
    REG_DELAY     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                   enable;
    logic [GAIN_BITS-1:0]   gain_top;
    logic [GAIN_BITS-1:0]   gain_bottom;
    logic [GAIN_BITS-1:0]   hang_threshold;
    logic [HANG_BITS-1:0]   hang_samples;
    logic [WEIGHT_BITS-1:0] attack_weight;
    logic [WEIGHT_BITS-1:0] decay_weight;
    logic [8:0]             delay_samples;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_DIV, ST_BLEND_A, ST_BLEND_B, ST_SCALE_A, ST_SCALE_B
  } state_t;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE  = 24'd65536;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX  = 24'hFFFFFF;

endpackage

// File: design/hagc_sqrt.sv
// Bit-serial integer square root, two result bits per cycle.
// Depends on hagc_pkg.
module hagc_sqrt
  import hagc_pkg::*;
#(
  parameter int IN_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [IN_BITS-1:0]   value,
  output logic                 done,
  output logic [IN_BITS/2-1:0] root
);

  // IN_BITS is a multiple of four so that every cycle takes two whole result bits.
  localparam int RB = IN_BITS / 2;
  localparam int CW = $clog2(RB + 1);

  logic [IN_BITS-1:0] rem;
  logic [IN_BITS-1:0] rad;
  logic [RB-1:0]      res;
  logic [CW-1:0]      cnt;
  logic               busy;

  logic [IN_BITS-1:0] rem1, rad1, rem2, rad2;
  logic [RB-1:0]      res1, res2;
  logic [IN_BITS+1:0] tr1, tr2;

  // One restoring step per half; each consumes two radicand bits.
  always_comb begin
    tr1  = {2'b00, rem[IN_BITS-3:0], rad[IN_BITS-1 -: 2]} - (IN_BITS+2)'({res, 2'b01});
    if (!tr1[IN_BITS+1]) begin
      rem1 = tr1[IN_BITS-1:0];
      res1 = {res[RB-2:0], 1'b1};
    end else begin
      rem1 = {rem[IN_BITS-3:0], rad[IN_BITS-1 -: 2]};
      res1 = {res[RB-2:0], 1'b0};
    end
    rad1 = {rad[IN_BITS-3:0], 2'b00};
    tr2  = {2'b00, rem1[IN_BITS-3:0], rad1[IN_BITS-1 -: 2]} - (IN_BITS+2)'({res1, 2'b01});
    if (!tr2[IN_BITS+1]) begin
      rem2 = tr2[IN_BITS-1:0];
      res2 = {res1[RB-2:0], 1'b1};
    end else begin
      rem2 = {rem1[IN_BITS-3:0], rad1[IN_BITS-1 -: 2]};
      res2 = {res1[RB-2:0], 1'b0};
    end
    rad2 = {rad1[IN_BITS-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RB / 2);
        rem  <= '0;
        res  <= '0;
        rad  <= value;
      end else if (busy) begin
        rem <= rem2;
        res <= res2;
        rad <= rad2;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign root = res;

endmodule

// File: design/hagc_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
// Depends on hagc_pkg.
module hagc_div
  import hagc_pkg::*;
#(
  parameter int NUM_BITS = 41,
  parameter int DEN_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]  den,
  output logic                 done,
  output logic [GAIN_BITS-1:0] quot
);

  localparam int CW = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] d;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [DEN_BITS:0]   sh;
  logic [DEN_BITS+1:0] diff;

  always_comb begin
    sh   = {rem[DEN_BITS-1:0], q[NUM_BITS-1]};
    diff = {1'b0, sh} - {2'b00, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_BITS);
        q    <= num;
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (!diff[DEN_BITS+1]) begin
          rem <= diff[DEN_BITS:0];
          q   <= {q[NUM_BITS-2:0], 1'b1};
        end else begin
          rem <= sh;
          q   <= {q[NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quot = (|q[NUM_BITS-1:GAIN_BITS]) ? GAIN_MAX : q[GAIN_BITS-1:0];

endmodule

// File: design/hang_agc_sample_gain.sv
// Hang AGC top level: config registers, delay memory, gain update and output stage.
// Depends on hagc_pkg, hagc_sqrt and hagc_div.
//
// Usage: samples arrive on the s_axis channel (tdata = sample_i, sample_q;
// tlast = in_last) and leave on m_axis with the same layout.
// Each transfer gives exactly one output transfer. The user must write
// registers through cfg_we, cfg_index and cfg_data only while no sample
// is in flight; the block itself does not enforce this.
// Enabled, one sample is handled at a time: square root (13 steps of two
// bits), reciprocal division (one quotient bit per cycle for 41 bits),
// then blend, write-back, delay read and scaling. A zero magnitude skips
// the divider. Disabled, a sample passes through unscaled to the output
// register. Reset restores gain 1.0 and register defaults, then clears
// every delay memory entry in a pass during which no sample is taken
// (configuration writes are taken). A result waits in the output register
// while m_axis_tready is low; the next sample is taken meanwhile but holds
// in its scaling stage until that register is free.
module hang_agc_sample_gain
  import hagc_pkg::*;
#(
  parameter int MAX_DELAY   = 512,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata from bit 0: sample_i, sample_q, zero fill
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                     s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata from bit 0: out_i, out_q, zero fill
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                     m_axis_tlast
);

  localparam int SB   = SAMPLE_BITS;
  localparam int TW   = ((2*SB+7)/8)*8;
  localparam int AW   = $clog2(MAX_DELAY);
  localparam int PWB  = 2*SB + 2;          // i*i+q*q
  localparam int SQB  = PWB + 16;          // radicand, padded to a multiple of four
  localparam int SQI  = ((SQB + 3) / 4) * 4;
  localparam int RB   = SQI / 2;
  localparam int NUMB = SB + 25;           // 10 << (SB+21) needs SB+25 bits
  localparam int DENB = RB + 4;
  localparam logic [NUMB-1:0] NUMER = NUMB'(10) << (SB + 21);
  localparam logic [AW-1:0]  DMAX = AW'(MAX_DELAY - 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.gain_top       <= 24'd163840;
      cfg.gain_bottom    <= 24'd66;
      cfg.hang_threshold <= 24'd230;
      cfg.hang_samples   <= 16'd24000;
      cfg.attack_weight  <= 17'd32768;
      cfg.decay_weight   <= 17'd128;
      cfg.delay_samples  <= 9'd288;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:   cfg.enable         <= cfg_data[0];
        REG_GAIN_TOP: cfg.gain_top       <= cfg_data[23:0];
        REG_GAIN_BOT: cfg.gain_bottom    <= cfg_data[23:0];
        REG_HANG_THR: cfg.hang_threshold <= cfg_data[23:0];
        REG_HANG_SMP: cfg.hang_samples   <= cfg_data[15:0];
        REG_ATTACK_W: cfg.attack_weight  <= cfg_data[16:0];
        REG_DECAY_W:  cfg.decay_weight   <= cfg_data[16:0];
        REG_DELAY:    cfg.delay_samples  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Delay memory.
  logic [2*SB-1:0] mem [MAX_DELAY];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [2*SB-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  state_t state, state_next;
  logic                    clearing;
  logic [AW-1:0]           clr_addr;
  logic [AW-1:0]           write_pos;
  logic [GAIN_BITS-1:0]    gain_now;
  logic [HANG_BITS-1:0]    hang_left;
  logic signed [SB-1:0]    si, sq;
  logic                    last;
  logic [GAIN_BITS-1:0]    target, scale;
  logic [GAIN_BITS-1:0]    blend_x;
  logic [WEIGHT_BITS-1:0]  blend_w;
  logic                    held;
  logic signed [SB-1:0]    di, dq;
  logic [AW-1:0]           rd_addr;
  // Sqrt starts the cycle after a sample is taken so that si/sq are loaded.
  logic                    sq_go;
  logic                    out_load;

  logic                  sq_start, sq_done, dv_start, dv_done;
  logic [RB-1:0]         m8;
  logic [GAIN_BITS-1:0]  quot;
  logic [SQI-1:0]        radicand;
  logic [PWB-1:0]        pw;

  always_comb begin
    pw = PWB'($signed(si) * $signed(si)) + PWB'($signed(sq) * $signed(sq));
    radicand = SQI'({pw, 16'd0});
  end

  hagc_sqrt #(.IN_BITS(SQI)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(radicand),
    .done(sq_done), .root(m8)
  );

  hagc_div #(.NUM_BITS(NUMB), .DEN_BITS(DENB)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(NUMER),
    .den(DENB'(m8) * DENB'(11)), .done(dv_done), .quot(quot)
  );

  assign s_axis_tready = (state == ST_IDLE) && !clearing;
  assign out_load = (state == ST_SCALE_B) && (!m_axis_tvalid || m_axis_tready);

  // Delay read address, with the effective delay clamped to MAX_DELAY-1.
  logic [AW-1:0] dly;
  always_comb begin
    if (32'(cfg.delay_samples) >= MAX_DELAY) dly = DMAX;
    else dly = AW'(cfg.delay_samples);
    if (AW'(MAX_DELAY) == '0) rd_addr = write_pos - dly;
    else if (write_pos >= dly) rd_addr = write_pos - dly;
    else rd_addr = AW'(32'(write_pos) + MAX_DELAY - 32'(dly));
  end

  // Blend multiply-accumulate: w*x + (1-w)*gain, rounded at bit 16.
  logic [40:0] blend_sum;
  always_comb begin
    blend_sum = 41'(blend_w) * 41'(blend_x)
              + 41'(17'd65536 - blend_w) * 41'(gain_now) + 41'd32768;
  end

  logic signed [SB+25:0] prod_i, prod_q;
  logic signed [SB-1:0]  sat_i, sat_q;
  always_comb begin
    prod_i = (SB+26)'(di) * $signed({2'b0, scale}) + (SB+26)'(32768);
    prod_q = (SB+26)'(dq) * $signed({2'b0, scale}) + (SB+26)'(32768);
    // Arithmetic shift floors, which matches round-half-up.
    if ((prod_i >>> 16) > (SB+26)'(SMAX)) sat_i = SMAX;
    else if ((prod_i >>> 16) < (SB+26)'(SMIN)) sat_i = SMIN;
    else sat_i = SB'(prod_i >>> 16);
    if ((prod_q >>> 16) > (SB+26)'(SMAX)) sat_q = SMAX;
    else if ((prod_q >>> 16) < (SB+26)'(SMIN)) sat_q = SMIN;
    else sat_q = SB'(prod_q >>> 16);
  end

  always_comb begin
    state_next = state;
    sq_start = sq_go;
    dv_start = 1'b0;
    mem_we = 1'b0;
    mem_waddr = write_pos;
    mem_wdata = {sq, si};
    mem_raddr = rd_addr;
    if (clearing) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end
    unique case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_SQRT;
      ST_SQRT: if (sq_done) state_next = ST_DIV;
      ST_DIV:  if (dv_done || m8 == '0) state_next = ST_BLEND_A;
      ST_BLEND_A: state_next = ST_BLEND_B;
      ST_BLEND_B: state_next = ST_SCALE_A;
      ST_SCALE_A: state_next = ST_SCALE_B;
      ST_SCALE_B: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (state == ST_IDLE && s_axis_tvalid && s_axis_tready && !cfg.enable)
      state_next = ST_SCALE_B;
    if (state == ST_SQRT && sq_done) dv_start = (m8 != '0);
    if (state == ST_BLEND_B) mem_we = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      write_pos <= '0;
      gain_now  <= GAIN_ONE;
      hang_left <= '0;
      sq_go     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      sq_go <= (state == ST_IDLE) && s_axis_tvalid && s_axis_tready && cfg.enable;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == DMAX) clearing <= 1'b0;
      end
      if (state == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
        si   <= $signed(s_axis_tdata[SB-1:0]);
        sq   <= $signed(s_axis_tdata[2*SB-1:SB]);
        last <= s_axis_tlast;
      end
      if (state == ST_DIV && (dv_done || m8 == '0)) begin
        if (m8 == '0) target <= gain_now;
        else target <= quot;
      end
      if (state == ST_BLEND_A) begin
        if (target >= gain_now) begin
          blend_w <= (cfg.decay_weight > 17'd65536) ? 17'd65536 : cfg.decay_weight;
          blend_x <= (target < cfg.gain_top) ? target : cfg.gain_top;
          if (target < cfg.hang_threshold) hang_left <= '0;
          else if (hang_left > '0) hang_left <= hang_left - 1'b1;
          held <= ~((target < cfg.hang_threshold) || hang_left == '0);
        end else begin
          blend_w <= (cfg.attack_weight > 17'd65536) ? 17'd65536 : cfg.attack_weight;
          blend_x <= (target > cfg.gain_bottom) ? target : cfg.gain_bottom;
          hang_left <= cfg.hang_samples;
          held <= 1'b0;
        end
      end
      if (state == ST_BLEND_B) begin
        // held set means the hang counter held the gain.
        logic [GAIN_BITS-1:0] g;
        g = held ? gain_now : blend_sum[39:16];
        if (g > cfg.gain_top) g = cfg.gain_top;
        if (g < cfg.gain_bottom) g = cfg.gain_bottom;
        gain_now <= g;
        scale <= (g < cfg.gain_top) ? g : cfg.gain_top;
        write_pos <= (write_pos == DMAX) ? '0 : write_pos + 1'b1;
      end
      if (state == ST_SCALE_A) begin
        // With zero delay the memory read returned the old entry, so use the new sample.
        di <= (dly == '0) ? si : $signed(mem_rdata[SB-1:0]);
        dq <= (dly == '0) ? sq : $signed(mem_rdata[2*SB-1:SB]);
      end
      if (out_load) begin
        if (cfg.enable) begin
          m_axis_tdata <= TW'({sat_q, sat_i});
        end else begin
          m_axis_tdata <= TW'({sq, si});
        end
        m_axis_tlast <= last;
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

endmodule
